/* rtl/core/vag_pkg.sv */
// Shared constants, codes and types for the voxel automaton block.
package vag_pkg;

  localparam int VAG_MAX_SIDE = 16;

  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 13;
  localparam int SIDE_W  = 5;
  localparam int NBR_W   = 5;

  localparam logic [SIDE_W-1:0] SIDE_RESET    = SIDE_W'(5);
  localparam logic [NBR_W-1:0]  MAX_NEIGHBORS = NBR_W'(26);
  localparam logic [NBR_W-1:0]  GENESIS_COUNT = NBR_W'(6);

  localparam logic [BYTE_W-1:0] MARK_DEATH   = 8'b0001_0000;
  localparam logic [BYTE_W-1:0] MARK_GENESIS = 8'b0100_0000;
  localparam logic [BYTE_W-1:0] ALIVE_BIT    = 8'b1000_0000;

  // request kinds; the fourth code is a no-op
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_t;

  // per-axis neighbor offset: -1, 0, +1
  typedef enum logic [1:0] {
    OFS_NEG  = 2'd0,
    OFS_ZERO = 2'd1,
    OFS_POS  = 2'd2
  } ofs_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_GEOM1,
    ST_GEOM2,
    ST_IDLE,
    ST_READ,
    ST_ADV_NB,
    ST_ADV_WB,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_ADV_END,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/vag_ifs.sv */
// Handshake channel interfaces: requests, results and side configuration.
interface vag_req_if;
  logic                         valid;
  logic                         ready;
  logic [vag_pkg::KIND_W-1:0]   kind;
  logic [vag_pkg::ADDR_W-1:0]   cell_address;
  logic [vag_pkg::BYTE_W-1:0]   cell_value;
  modport source(output valid, kind, cell_address, cell_value, input ready);
  modport sink(input valid, kind, cell_address, cell_value, output ready);
endinterface

interface vag_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vag_pkg::BYTE_W-1:0]   read_value;
  logic [vag_pkg::COUNT_W-1:0]  births;
  logic [vag_pkg::COUNT_W-1:0]  deaths;
  modport source(output valid, read_value, births, deaths, input ready);
  modport sink(input valid, read_value, births, deaths, output ready);
endinterface

interface vag_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [vag_pkg::SIDE_W-1:0]   grid_side;
  modport source(output valid, grid_side, input ready);
  modport sink(input valid, grid_side, output ready);
endinterface

/* rtl/core/vag_grid_mem.sv */
// Cell store: one write port, one registered read port, two banks of the cube.
module vag_grid_mem #(
  parameter int AW = 13
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [vag_pkg::BYTE_W-1:0]   wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [vag_pkg::BYTE_W-1:0]   rdata
);
  import vag_pkg::*;

  localparam int DEPTH = 2 ** AW;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/vag_cell_rule.sv */
// Generation rule for one cell: mark from neighbor count, then resolve.
module vag_cell_rule (
  input  logic [vag_pkg::BYTE_W-1:0] cell_old,
  input  logic [vag_pkg::NBR_W-1:0]  nbr_count,
  output logic [vag_pkg::BYTE_W-1:0] cell_new,
  output logic                       birth,
  output logic                       death
);
  import vag_pkg::*;

  logic [BYTE_W-1:0] mark;
  logic              odd_low;

  // odd counts up to seven
  assign odd_low = nbr_count[0] && (nbr_count < NBR_W'(8));

  always_comb begin
    mark  = cell_old;
    birth = 1'b0;
    if ((cell_old & ALIVE_BIT) != '0) begin
      if (odd_low) begin
        mark = MARK_DEATH;
      end
    end else if (nbr_count == GENESIS_COUNT) begin
      mark  = MARK_GENESIS;
      birth = 1'b1;
    end

    death = 1'b0;
    if ((mark & MARK_DEATH) != '0) begin
      cell_new = '0;
      death    = 1'b1;
    end else if ((mark & MARK_GENESIS) != '0) begin
      cell_new = mark | ALIVE_BIT;
    end else if ((mark & ALIVE_BIT) == '0) begin
      cell_new = mark >> 1;
    end else begin
      cell_new = mark;
    end
  end

endmodule

/* rtl/core/voxel_automaton_generation.sv */
// Voxel automaton top level: cell store, generation sequencer and channels.
//
//  channel | dir | payload                              | handshake
//  --------+-----+--------------------------------------+-------------
//  req     | in  | kind, cell_address, cell_value       | valid/ready
//  rsp     | out | read_value, births, deaths           | valid/ready
//  cfg     | in  | grid_side                            | valid/ready
//
// Write and read load rsp after the store access; side write: side^2, then side^3 on the
// multiplier. Advance: one read port steps through all 27 offsets of each neighborhood,
// reading those in the cube; entries past the cube are copied to the new bank. After
// reset a clearing pass writes MAX_SIDE^3 zeros and sets up the geometry before req is
// ready. One request in flight; the next is taken while the result waits on rsp.
module voxel_automaton_generation #(
  parameter int MAX_SIDE = vag_pkg::VAG_MAX_SIDE
) (
  input logic       clk,
  input logic       rst,
  vag_req_if.sink   req,
  vag_rsp_if.source rsp,
  vag_cfg_if.sink   cfg
);
  import vag_pkg::*;

  localparam int CELLS = MAX_SIDE ** 3;
  localparam int AW    = $clog2(CELLS);
  localparam int TW    = AW + 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = $clog2(MAX_SIDE);
  localparam int S2W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int MAW   = AW + 1;

  state_t state, state_next;

  logic [SIDE_W-1:0]  grid_side;
  logic [SW-1:0]      side;
  logic [S2W-1:0]     side_sq;
  logic [TW-1:0]      total;
  logic               bank;

  logic [TW-1:0]      idx;
  logic [CW-1:0]      x, y, z;
  ofs_t               dx, dy, dz;
  logic [NBR_W-1:0]   nbr_cnt;
  logic               pend_nb, pend_self;
  logic [BYTE_W-1:0]  m_self;
  logic [COUNT_W-1:0] births, deaths;
  logic               rd_hit;

  logic [BYTE_W-1:0]  res_read;
  logic [COUNT_W-1:0] res_births, res_deaths;

  logic               mem_we, mem_re;
  logic [MAW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]  mem_wdata, mem_rdata;

  logic               accept, cfg_write, hit, out_load;
  logic [AW-1:0]      addr_lo, nb_addr, tx, ty, tz, side_a, side_sq_a;
  logic               x_in, y_in, z_in, nb_in, nb_self, nb_last;
  logic               x_end, y_end, cell_last, copy_last, clear_last;
  logic               nb_live;
  logic [NBR_W-1:0]   nbr_final;
  logic [BYTE_W-1:0]  cell_new;
  logic               birth, death;

  // side in use, clamped to 1..MAX_SIDE
  always_comb begin
    if (grid_side == '0) begin
      side = SW'(1);
    end else if (int'(grid_side) > MAX_SIDE) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(grid_side);
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = (state == ST_IDLE) && !req.valid;
  assign accept    = req.valid && req.ready;
  assign cfg_write = cfg.valid && cfg.ready;
  assign hit       = 32'(req.cell_address) < 32'(total);
  assign addr_lo   = AW'(req.cell_address);
  assign out_load  = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  // neighbor address and bounds for the current offset
  assign side_a    = AW'(side);
  assign side_sq_a = AW'(side_sq);
  assign tx = (dx == OFS_NEG) ? '1 : (dx == OFS_POS) ? AW'(1) : '0;
  assign ty = (dy == OFS_NEG) ? AW'(0) - side_a : (dy == OFS_POS) ? side_a : '0;
  assign tz = (dz == OFS_NEG) ? AW'(0) - side_sq_a : (dz == OFS_POS) ? side_sq_a : '0;
  assign nb_addr = idx[AW-1:0] + tz + ty + tx;

  assign x_in = (dx == OFS_NEG) ? (x != '0) :
                (dx == OFS_POS) ? (SW'(x) + SW'(1) != side) : 1'b1;
  assign y_in = (dy == OFS_NEG) ? (y != '0) :
                (dy == OFS_POS) ? (SW'(y) + SW'(1) != side) : 1'b1;
  assign z_in = (dz == OFS_NEG) ? (z != '0) :
                (dz == OFS_POS) ? (SW'(z) + SW'(1) != side) : 1'b1;
  assign nb_in   = x_in && y_in && z_in;
  assign nb_self = (dx == OFS_ZERO) && (dy == OFS_ZERO) && (dz == OFS_ZERO);
  assign nb_last = (dx == OFS_POS) && (dy == OFS_POS) && (dz == OFS_POS);

  assign x_end      = (SW'(x) + SW'(1) == side);
  assign y_end      = (SW'(y) + SW'(1) == side);
  assign cell_last  = (TW'(idx + TW'(1)) == total);
  assign copy_last  = (idx == TW'(CELLS - 1));
  assign clear_last = copy_last;

  assign nb_live   = pend_nb && (mem_rdata != '0);
  assign nbr_final = nbr_cnt + NBR_W'(nb_live);

  vag_cell_rule u_rule (
    .cell_old  (m_self),
    .nbr_count (nbr_final),
    .cell_new  (cell_new),
    .birth     (birth),
    .death     (death)
  );

  vag_grid_mem #(.AW(MAW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, idx[AW-1:0]};
        if (clear_last) begin
          state_next = ST_GEOM1;
        end
      end
      ST_GEOM1: state_next = ST_GEOM2;
      ST_GEOM2: state_next = ST_IDLE;
      ST_IDLE: begin
        if (cfg_write) begin
          state_next = ST_GEOM1;
        end else if (accept) begin
          case (req.kind)
            KIND_WRITE: begin
              mem_we     = hit;
              mem_waddr  = {bank, addr_lo};
              mem_wdata  = req.cell_value;
              state_next = ST_DONE;
            end
            KIND_READ: begin
              mem_re     = hit;
              mem_raddr  = {bank, addr_lo};
              state_next = ST_READ;
            end
            KIND_ADVANCE: state_next = ST_ADV_NB;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_ADV_NB: begin
        mem_re    = nb_in;
        mem_raddr = {bank, nb_addr};
        if (nb_last) begin
          state_next = ST_ADV_WB;
        end
      end
      ST_ADV_WB: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank, idx[AW-1:0]};
        mem_wdata = cell_new;
        if (!cell_last) begin
          state_next = ST_ADV_NB;
        end else if (total == TW'(CELLS)) begin
          state_next = ST_ADV_END;
        end else begin
          state_next = ST_COPY_RD;
        end
      end
      ST_COPY_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = {bank, idx[AW-1:0]};
        state_next = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = {~bank, idx[AW-1:0]};
        mem_wdata  = mem_rdata;
        state_next = copy_last ? ST_ADV_END : ST_COPY_RD;
      end
      ST_ADV_END: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= SIDE_RESET;
      bank      <= 1'b0;
      idx       <= '0;
      x         <= '0;
      y         <= '0;
      z         <= '0;
      dx        <= OFS_NEG;
      dy        <= OFS_NEG;
      dz        <= OFS_NEG;
      nbr_cnt   <= '0;
      pend_nb   <= 1'b0;
      pend_self <= 1'b0;
      rd_hit    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        grid_side <= cfg.grid_side;
      end

      case (state)
        ST_CLEAR: begin
          idx <= clear_last ? '0 : TW'(idx + TW'(1));
        end
        ST_GEOM1: side_sq <= S2W'(32'(side) * 32'(side));
        ST_GEOM2: total   <= TW'(32'(side_sq) * 32'(side));
        ST_IDLE: begin
          if (accept) begin
            res_read   <= '0;
            res_births <= '0;
            res_deaths <= '0;
            rd_hit     <= hit;
            idx        <= '0;
            x          <= '0;
            y          <= '0;
            z          <= '0;
            dx         <= OFS_NEG;
            dy         <= OFS_NEG;
            dz         <= OFS_NEG;
            nbr_cnt    <= '0;
            pend_nb    <= 1'b0;
            pend_self  <= 1'b0;
            births     <= '0;
            deaths     <= '0;
          end
        end
        ST_READ: begin
          if (rd_hit) begin
            res_read <= mem_rdata;
          end
        end
        ST_ADV_NB: begin
          // data of the previous offset arrives this cycle
          pend_nb   <= nb_in && !nb_self;
          pend_self <= nb_self;
          nbr_cnt   <= nbr_final;
          if (pend_self) begin
            m_self <= mem_rdata;
          end
          if (dx != OFS_POS) begin
            dx <= ofs_t'(dx + 2'd1);
          end else begin
            dx <= OFS_NEG;
            if (dy != OFS_POS) begin
              dy <= ofs_t'(dy + 2'd1);
            end else begin
              dy <= OFS_NEG;
              dz <= (dz != OFS_POS) ? ofs_t'(dz + 2'd1) : OFS_NEG;
            end
          end
        end
        ST_ADV_WB: begin
          pend_nb   <= 1'b0;
          pend_self <= 1'b0;
          nbr_cnt   <= '0;
          births    <= births + COUNT_W'(birth);
          deaths    <= deaths + COUNT_W'(death);
          idx       <= TW'(idx + TW'(1));
          if (x_end) begin
            x <= '0;
            if (y_end) begin
              y <= '0;
              z <= CW'(z + CW'(1));
            end else begin
              y <= CW'(y + CW'(1));
            end
          end else begin
            x <= CW'(x + CW'(1));
          end
        end
        ST_COPY_WR: idx <= TW'(idx + TW'(1));
        ST_ADV_END: begin
          bank       <= ~bank;
          res_births <= births;
          res_deaths <= deaths;
        end
        default: ;
      endcase

      if (out_load) begin
        rsp.valid      <= 1'b1;
        rsp.read_value <= res_read;
        rsp.births     <= res_births;
        rsp.deaths     <= res_deaths;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  a_nbr_bound: assert property (@(posedge clk) disable iff (rst)
    nbr_cnt <= MAX_NEIGHBORS)
    else $error("neighbor count above 26");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (bank != $past(bank)) |-> ($past(state) == ST_ADV_END))
    else $error("bank swapped outside generation end");

  a_new_bank: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == ST_ADV_WB || state == ST_COPY_WR)) |-> (mem_waddr[AW] != bank))
    else $error("generation wrote the live bank");

  a_rsp_excl: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.births != '0 || rsp.deaths != '0)) |-> (rsp.read_value == '0))
    else $error("read value and counts both nonzero");

endmodule
